[src/spk_pkg.sv]
// shared constants, types and the column transpose for the spectrum peak display
package spk_pkg;

   localparam int NUM_BINS   = 16;
   localparam int NUM_LANES  = 6;
   localparam int FREQ_W     = 32;
   localparam int BIN_W      = 4;
   localparam int BYTE_W     = 8;
   localparam int ROWS       = 8;
   localparam int NUM_BYTES  = 2 * ROWS;
   localparam int HALF_COLS  = NUM_BINS / 2;
   localparam int CLAMP_BIT  = 15;
   localparam int COUNT_W    = 4;

   localparam logic [BYTE_W-1:0]  PEAK_RESET = 8'h80;
   localparam logic [BYTE_W-1:0]  FULL_COL   = 8'hff;
   localparam logic [BIN_W-1:0]   MAX_BIN    = 4'd15;
   localparam logic [COUNT_W-1:0] FPU_RESET  = 4'd5;

   typedef logic [NUM_BINS-1:0][BYTE_W-1:0]  col_array_type;
   typedef logic [NUM_BYTES-1:0][BYTE_W-1:0] byte_array_type;
   typedef logic [NUM_LANES-1:0][FREQ_W-1:0] freq_array_type;

   // one lane's finding: whether the tone marks a bin, and which one
   typedef struct packed {
      logic             hit;
      logic [BIN_W-1:0] bin;
   } mark_type;

   typedef mark_type [NUM_LANES-1:0] mark_array_type;

   // merged bin mask waiting for the state update
   typedef struct packed {
      logic                valid;
      logic [NUM_BINS-1:0] mask;
   } stage_type;

   // hand-off of a finished column set to the output side
   typedef struct packed {
      logic          load;
      col_array_type cols;
   } emit_type;

   // byte k covers row k/2, left half for even k and right half for odd k
   function automatic byte_array_type transpose_cols(input col_array_type cols);
      byte_array_type b;
      b = '0;
      for (int k = 0; k < NUM_BYTES; k++) begin
         for (int j = 0; j < HALF_COLS; j++) begin
            b[k][j] = cols[(k % 2) * HALF_COLS + j][ROWS - 1 - (k / 2)];
         end
      end
      return b;
   endfunction

endpackage

[src/spk_tone_lane.sv]
// one lane: floor log2 of a tone frequency, clamped, as a bin mark
module spk_tone_lane
   import spk_pkg::*;
(
   input  logic [FREQ_W-1:0] freq,
   output mark_type          mark
);

   // leading one search; anything at or above the clamp bit lands in the top bin
   always_comb begin
      mark.hit = |freq[FREQ_W-1:1];
      mark.bin = '0;
      if (|freq[FREQ_W-1:CLAMP_BIT]) begin
         mark.bin = MAX_BIN;
      end else begin
         for (int i = 1; i < CLAMP_BIT; i++) begin
            if (freq[i]) begin
               mark.bin = BIN_W'(i);
            end
         end
      end
   end

endmodule

[src/spk_merge.sv]
// merging stage: combines the lane marks into one registered bin mask
module spk_merge
   import spk_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  mark_array_type marks,
   input  logic           taken,
   output stage_type      stage
);

   logic                valid_ff, valid_in;
   logic [NUM_BINS-1:0] mask_ff, mask_in;
   logic [NUM_BINS-1:0] merged;

   // or together the one-hot decode of every lane
   always_comb begin
      merged = '0;
      for (int l = 0; l < NUM_LANES; l++) begin
         if (marks[l].hit) begin
            merged[marks[l].bin] = 1'b1;
         end
      end
   end

   assign in_ready = !valid_ff || taken;

   // stage register, refilled whenever it empties or moves on
   always_comb begin
      valid_in = valid_ff;
      mask_in  = mask_ff;
      if (in_ready) begin
         valid_in = in_valid;
         mask_in  = merged;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      mask_ff <= mask_in;
   end

   assign stage.valid = valid_ff;
   assign stage.mask  = mask_ff;

endmodule

[src/spk_bins.sv]
// bin state: peaks, columns, frame divider and the update register
module spk_bins
   import spk_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [COUNT_W-1:0] csr_write_data,
   input  stage_type          stage,
   input  logic               buf_free,
   output logic               taken,
   output emit_type           emit
);

   col_array_type      peak_ff, peak_in;
   col_array_type      col_ff, col_in;
   col_array_type      col_or;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] fpu_ff, fpu_in;
   logic [COUNT_W:0]   count_next;
   logic               show;

   assign show  = (count_ff == '0);
   assign taken = stage.valid && (!show || buf_free);

   // columns with marks and peaks folded in, as the display sees them
   always_comb begin
      for (int i = 0; i < NUM_BINS; i++) begin
         col_or[i] = stage.mask[i] ? FULL_COL : (col_ff[i] | peak_ff[i]);
      end
   end

   assign emit.load = taken && show;
   assign emit.cols = col_or;

   assign count_next = {1'b0, count_ff} + 1'b1;

   // per-transaction update of peaks, columns and divider, plus the csr write of frames per update
   always_comb begin
      peak_in  = peak_ff;
      col_in   = col_ff;
      count_in = count_ff;
      fpu_in   = csr_write_enable ? csr_write_data : fpu_ff;
      if (taken) begin
         for (int i = 0; i < NUM_BINS; i++) begin
            peak_in[i] = stage.mask[i] ? PEAK_RESET : peak_ff[i];
            if (show && (peak_in[i] > 8'd1)) begin
               peak_in[i] = peak_in[i] >> 1;
            end
         end
         if (count_next > {1'b0, fpu_ff}) begin
            count_in = '0;
            col_in   = '0;
         end else begin
            count_in = count_next[COUNT_W-1:0];
            col_in   = col_or;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BINS; i++) begin
            peak_ff[i] <= PEAK_RESET;
         end
         col_ff   <= '0;
         count_ff <= '0;
         fpu_ff   <= FPU_RESET;
      end else begin
         peak_ff  <= peak_in;
         col_ff   <= col_in;
         count_ff <= count_in;
         fpu_ff   <= fpu_in;
      end
   end

endmodule

[src/spk_serializer.sv]
// output side: transposed display bytes shifted out one transaction at a time
module spk_serializer
   import spk_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  emit_type          emit,
   output logic              buf_free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BIN_W-1:0]  rsp_byte_index,
   output logic [BYTE_W-1:0] rsp_byte_value,
   output logic              rsp_last_byte
);

   byte_array_type   bytes_ff, bytes_in;
   logic [BIN_W-1:0] idx_ff, idx_in;
   logic             busy_ff, busy_in;
   logic             last;
   logic             fire;

   assign last     = (idx_ff == BIN_W'(NUM_BYTES - 1));
   assign fire     = busy_ff && rsp_ready;
   assign buf_free = !busy_ff || (fire && last);

   // load a fresh set, or shift one byte out per transaction
   always_comb begin
      bytes_in = bytes_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      if (emit.load) begin
         bytes_in = transpose_cols(emit.cols);
         idx_in   = '0;
         busy_in  = 1'b1;
      end else if (fire) begin
         for (int k = 0; k < NUM_BYTES - 1; k++) begin
            bytes_in[k] = bytes_ff[k+1];
         end
         idx_in = idx_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      bytes_ff <= bytes_in;
   end

   assign rsp_valid      = busy_ff;
   assign rsp_byte_index = idx_ff;
   assign rsp_byte_value = bytes_ff[0];
   assign rsp_last_byte  = busy_ff && last;

endmodule

[src/spectrum_peak_hold_led_matrix_top.sv]
// top level of the spectrum peak-hold display for a 16 by 8 led matrix
//
// req channel: one transaction per audio frame with three right and three left
// tone frequencies. six log2 lanes work side by side and a merge register
// collects their bin marks; the state update takes its mask from that register.
// rsp channel: on frames where the divider reads zero, sixteen transactions
// carry the display bytes, index 0 to 15, last_byte high on index 15.
// other frames produce no transaction.
// an update passes the merge register, waits there while the output shift
// register drains its previous update, and is then loaded into that shift
// register; its bytes follow one per cycle while rsp_ready is high, and the
// final byte of one update and the next load overlap in the same cycle. a
// frame that causes no update is taken from the merge register without
// waiting, so such frames are taken back to back.
// csr_write_data is taken into frames_per_update whenever csr_write_enable
// is high. reset (synchronous) sets all peaks to 0x80, clears columns and
// the divider and sets frames_per_update to 5. a stalled rsp_ready holds the
// current byte; frames that do not show are still accepted meanwhile.
module spectrum_peak_hold_led_matrix_top
   import spk_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [FREQ_W-1:0]  req_right_freq_0,
   input  logic [FREQ_W-1:0]  req_right_freq_1,
   input  logic [FREQ_W-1:0]  req_right_freq_2,
   input  logic [FREQ_W-1:0]  req_left_freq_0,
   input  logic [FREQ_W-1:0]  req_left_freq_1,
   input  logic [FREQ_W-1:0]  req_left_freq_2,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BIN_W-1:0]   rsp_byte_index,
   output logic [BYTE_W-1:0]  rsp_byte_value,
   output logic               rsp_last_byte,
   input  logic               csr_write_enable,
   input  logic [COUNT_W-1:0] csr_write_data
);

   freq_array_type freqs;
   mark_array_type marks;
   stage_type      stage;
   emit_type       emit;
   logic           taken;
   logic           buf_free;

   // lane order: right tones first, then left
   assign freqs[0] = req_right_freq_0;
   assign freqs[1] = req_right_freq_1;
   assign freqs[2] = req_right_freq_2;
   assign freqs[3] = req_left_freq_0;
   assign freqs[4] = req_left_freq_1;
   assign freqs[5] = req_left_freq_2;

   // log2 lanes
   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      spk_tone_lane u_lane (
         .freq (freqs[l]),
         .mark (marks[l])
      );
   end

   spk_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .marks    (marks),
      .taken    (taken),
      .stage    (stage)
   );

   spk_bins u_bins (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .stage            (stage),
      .buf_free         (buf_free),
      .taken            (taken),
      .emit             (emit)
   );

   spk_serializer u_serializer (
      .clock          (clock),
      .reset          (reset),
      .emit           (emit),
      .buf_free       (buf_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_byte_index (rsp_byte_index),
      .rsp_byte_value (rsp_byte_value),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule

[src/spk_checker.sv]
// port-level checks for the spectrum peak-hold display, bound to the top level
module spk_checker
   import spk_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [BIN_W-1:0]   rsp_byte_index,
   input logic [BYTE_W-1:0]  rsp_byte_value,
   input logic               rsp_last_byte
);

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled byte holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_byte_index) && $stable(rsp_byte_value))
      else $error("stalled rsp transaction changed");

   // bytes of one update come out without gaps, in index order
   a_rsp_sequence: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_byte |=>
         rsp_valid && (rsp_byte_index == BIN_W'($past(rsp_byte_index) + 1'b1)))
      else $error("display bytes out of order");

   // the last flag marks the top index only
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_byte == (rsp_byte_index == BIN_W'(NUM_BYTES - 1))))
      else $error("last_byte does not match index");

   // a new update starts at index zero
   a_first_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> rsp_byte_index == '0)
      else $error("update does not start at byte zero");

endmodule

bind spectrum_peak_hold_led_matrix_top spk_checker u_spk_checker (.*);

[verif/tb_spectrum_peak_hold_led_matrix_top.sv]
// testbench for the spectrum peak-hold led matrix: predicts and checks every display byte
`timescale 1ns / 100ps

module tb_spectrum_peak_hold_led_matrix_top;
   import spk_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES   = 24;
   localparam int NUM_PHASES     = 9;
   localparam int FIXED_PHASES   = 5;
   localparam int PLAN_RATE [FIXED_PHASES] = '{15, 3, 0, 1, 15};
   localparam int PLAN_LEN  [FIXED_PHASES] = '{20, 12, 10, 12, 18};
   localparam int RANDOM_LEN     = 20;

   // one display byte as it leaves the block
   typedef struct packed {
      logic [BIN_W-1:0]  byte_index;
      logic [BYTE_W-1:0] byte_value;
      logic              last_byte;
   } disp_byte_type;

   // tracks peaks, columns and divider, and holds the display bytes still owed
   class peak_display_sb;
      logic [BYTE_W-1:0] peak [NUM_BINS];
      logic [BYTE_W-1:0] cols [NUM_BINS];
      int unsigned       frame_count;
      int unsigned       rate;
      disp_byte_type     owed_bytes [$];
      int                errors;

      function new();
         errors = 0;
         reset_state();
      endfunction

      function void reset_state();
         for (int i = 0; i < NUM_BINS; i++) begin
            peak[i] = PEAK_RESET;
            cols[i] = '0;
         end
         frame_count = 0;
         rate = 32'(FPU_RESET);
         owed_bytes.delete();
      endfunction

      function void set_rate(input logic [COUNT_W-1:0] v);
         rate = 32'(v);
      endfunction

      // floor(log2) of a tone, clamped; zero means no mark
      function int unsigned tone_bin(input logic [FREQ_W-1:0] f);
         int unsigned b;
         b = 0;
         for (int i = 1; i < FREQ_W; i++) begin
            if (f[i]) b = i;
         end
         if (b > CLAMP_BIT) b = CLAMP_BIT;
         return b;
      endfunction

      // update state for one accepted frame and queue its display bytes
      function void note_frame(input freq_array_type freqs);
         int unsigned   bin;
         bit            show;
         disp_byte_type d;
         show = (frame_count == 0);
         for (int i = 0; i < NUM_LANES; i++) begin
            bin = tone_bin(freqs[i]);
            if (bin != 0) begin
               peak[bin] = PEAK_RESET;
               cols[bin] = FULL_COL;
            end
         end
         // columns take their peak, peaks decay on display frames
         for (int i = 0; i < NUM_BINS; i++) begin
            cols[i] = cols[i] | peak[i];
            if (show && peak[i] > 1) peak[i] = peak[i] >> 1;
         end
         // row-wise transpose, even byte left half, odd byte right half
         if (show) begin
            for (int k = 0; k < NUM_BYTES; k++) begin
               d.byte_index = BIN_W'(k);
               for (int j = 0; j < HALF_COLS; j++) begin
                  d.byte_value[j] = cols[(k % 2) * HALF_COLS + j][ROWS - 1 - k / 2];
               end
               d.last_byte = (k == NUM_BYTES - 1);
               owed_bytes.push_back(d);
            end
         end
         // divider wrap clears the columns
         if (frame_count + 1 > rate) begin
            frame_count = 0;
            for (int i = 0; i < NUM_BINS; i++) cols[i] = '0;
         end else begin
            frame_count = frame_count + 1;
         end
      endfunction

      // compare one output transaction with the oldest owed byte
      function void check_byte(input logic [BIN_W-1:0] idx, input logic [BYTE_W-1:0] val,
                               input logic last);
         disp_byte_type want;
         if (owed_bytes.size() == 0) begin
            $display("%0t: unexpected byte index %0d value %02h last %0b",
                     $time, idx, val, last);
            errors++;
            return;
         end
         want = owed_bytes.pop_front();
         if (want.byte_index !== idx) begin
            $display("%0t: byte_index mismatch expected %0d actual %0d",
                     $time, want.byte_index, idx);
            errors++;
         end
         if (want.byte_value !== val) begin
            $display("%0t: byte_value mismatch at index %0d expected %02h actual %02h",
                     $time, want.byte_index, want.byte_value, val);
            errors++;
         end
         if (want.last_byte !== last) begin
            $display("%0t: last_byte mismatch at index %0d expected %0b actual %0b",
                     $time, want.byte_index, want.last_byte, last);
            errors++;
         end
      endfunction

      function int owed();
         return owed_bytes.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   freq_array_type      req_freqs = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [BIN_W-1:0]    rsp_byte_index;
   logic [BYTE_W-1:0]   rsp_byte_value;
   logic                rsp_last_byte;
   logic                csr_write_enable = 1'b0;
   logic [COUNT_W-1:0]  csr_write_data = '0;

   bit                  calm = 1'b0;
   int                  idle_cycles = 0;
   peak_display_sb      sb;

   spectrum_peak_hold_led_matrix_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_right_freq_0 (req_freqs[0]),
      .req_right_freq_1 (req_freqs[1]),
      .req_right_freq_2 (req_freqs[2]),
      .req_left_freq_0  (req_freqs[3]),
      .req_left_freq_1  (req_freqs[4]),
      .req_left_freq_2  (req_freqs[5]),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_last_byte    (rsp_last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(15, 50);
   endfunction

   // tone mix: zero, one, a random octave, or any 32-bit value
   function automatic logic [FREQ_W-1:0] rand_freq();
      int                mode;
      int                k;
      logic [FREQ_W-1:0] low_mask;
      mode = $urandom_range(0, 9);
      if (mode == 0) return '0;
      if (mode == 1) return 32'd1;
      if (mode < 7) begin
         k = $urandom_range(1, FREQ_W - 1);
         low_mask = (32'd1 << k) - 32'd1;
         return (32'd1 << k) | ($urandom & low_mask);
      end
      return $urandom;
   endfunction

   function automatic freq_array_type frame6(input logic [FREQ_W-1:0] r0, r1, r2, l0, l1, l2);
      freq_array_type f;
      f[0] = r0;
      f[1] = r1;
      f[2] = r2;
      f[3] = l0;
      f[4] = l1;
      f[5] = l2;
      return f;
   endfunction

   function automatic freq_array_type rand_frame();
      freq_array_type f;
      for (int i = 0; i < NUM_LANES; i++) f[i] = rand_freq();
      return f;
   endfunction

   // one req transaction; valid stays up when the next frame follows at once
   task automatic send_frame(input freq_array_type f);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_freqs <= f;
      do @(posedge clock); while (!req_ready);
      sb.note_frame(f);
   endtask

   // stop sending and wait until every owed byte is out and the pipeline is empty
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.owed() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rate(input logic [COUNT_W-1:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_rate(v);
   endtask

   // rsp_ready: high stretches with stalls, or always high in calm phases
   initial begin
      int stretch;
      @(posedge clock);
      forever begin
         if (calm) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            stretch = $urandom_range(1, 10);
            repeat (stretch) @(posedge clock);
            stretch = ($urandom_range(0, 15) < 14) ? $urandom_range(1, 3)
                                                   : $urandom_range(15, 50);
            rsp_ready <= 1'b0;
            repeat (stretch) @(posedge clock);
         end
      end
   end

   // output check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_byte(rsp_byte_index, rsp_byte_value, rsp_last_byte);
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles = idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      int unsigned rate;
      int          len;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: zero and one tones, top of range, every octave, clamping
      send_frame(frame6(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
      send_frame(frame6(32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1));
      send_frame(frame6('1, '1, '1, '1, '1, '1));
      send_frame(frame6(32'd2, 32'd3, 32'd4, 32'd7, 32'd8, 32'd15));
      send_frame(frame6(32'd16, 32'd32, 32'd64, 32'd128, 32'd256, 32'd512));
      send_frame(frame6(32'd1024, 32'd2048, 32'd4096, 32'd8192, 32'd16384, 32'd32768));
      send_frame(frame6(32'h0000_ffff, 32'h0001_0000, 32'h7fff_ffff,
                        32'h8000_0000, 32'h0000_0001, 32'h0000_0000));
      settle();

      // display every frame with no marks: peaks decay to one and hold there
      write_rate(4'd0);
      repeat (9) send_frame(frame6(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
      settle();

      // random phases; the second lowers the register below the running count
      for (int p = 0; p < NUM_PHASES; p++) begin
         rate = (p < FIXED_PHASES) ? PLAN_RATE[p] : $urandom_range(0, 15);
         len  = (p < FIXED_PHASES) ? PLAN_LEN[p] : RANDOM_LEN;
         calm = (p == 2) || ($urandom_range(0, 3) == 0);
         write_rate(rate[COUNT_W-1:0]);
         for (int i = 0; i < len; i++) send_frame(rand_frame());
         settle();
      end

      calm = 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.owed() != 0) begin
         $display("%0t: %0d display bytes never arrived", $time, sb.owed());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
